// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while the asynchronous reset is held.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/fqc_pkg.sv =====
// ---------------------------------------------------------------------------
// fqc_pkg
// Widths, command and status codes and the cell control type of the
// tagged queue with cancellation by id.
// ---------------------------------------------------------------------------
package fqc_pkg;

    localparam int ID_W  = 16;
    localparam int REF_W = 16;
    localparam int CMD_W = 2;
    localparam int ST_W  = 2;
    localparam int OCC_W = 5;

    localparam int DEFAULT_CAPACITY = 16;

    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TAKE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CANCEL = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd3;

    // Control broadcast to every cell for the item being accepted.
    typedef struct packed {
        logic take;    // shift the whole row up one place
        logic cancel;  // shift up every cell at or behind the first match
    } cell_ctl_t;

endpackage

// ===== src/fifo_queue_with_cancel_by_id.sv =====
// ---------------------------------------------------------------------------
// fifo_queue_with_cancel_by_id
// First-in first-out queue of tagged entries with add, take-head and
// cancel-by-id commands, built as a row of storage cells.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  tdata (low bit up)                    tuser (low bit up)
//  s_axis    in         entry_id[15:0] entry_ref[31:16]       command[1:0]
//  m_axis    out        taken_id[15:0] taken_ref[31:16]       status[1:0]
//                       occupancy[36:32] zero[39:37]          taken_valid[2]
//
// For each item the cells compare their ids with the key in parallel,
// the first match ripples down the row and the cells behind it take
// their neighbour's entry at the clock edge that accepts the item. The
// result goes into an output register, so one item per cycle is accepted
// while the consumer keeps m_tready high. A stalled result holds the input
// side back until it is taken. Reset empties the queue at once; the cell
// contents are not cleared, as only slots below the fill count are read.
//
module fifo_queue_with_cancel_by_id #(
    parameter int CAPACITY = fqc_pkg::DEFAULT_CAPACITY
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // entry_id[15:0], entry_ref[31:16]
    input  logic [1:0]  s_tuser,   // command[1:0]

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // taken_id[15:0], taken_ref[31:16],
                                   // occupancy[36:32], zero[39:37]
    output logic [2:0]  m_tuser    // status[1:0], taken_valid[2]
);
    import fqc_pkg::*;

    `include "assert_macros.svh"

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Input side.
    logic             s_fire;
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0]  in_id;
    logic [REF_W-1:0] in_ref;

    // Queue state.
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             is_empty, is_full, found;
    logic             add_ok, take_ok, cancel_ok;
    cell_ctl_t        ctl;

    // Cell row.
    logic [ID_W-1:0]  cell_id  [CAPACITY];
    logic [REF_W-1:0] cell_ref [CAPACITY];
    logic [CAPACITY:0] found_chain;

    // Output register.
    logic             out_valid_reg, out_valid_next;
    logic [ST_W-1:0]  out_status_reg, out_status_next;
    logic             out_taken_reg, out_taken_next;
    logic [ID_W-1:0]  out_id_reg, out_id_next;
    logic [REF_W-1:0] out_ref_reg, out_ref_next;
    logic [OCC_W-1:0] out_occ_reg, out_occ_next;
    logic [31:0]      fill_wide;

    assign s_tready = !out_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;
    assign cmd      = s_tuser;
    assign in_id    = s_tdata[ID_W-1:0];
    assign in_ref   = s_tdata[ID_W+REF_W-1:ID_W];

    assign is_empty = (fill_reg == '0);
    assign is_full  = (fill_reg == CNT_W'(CAPACITY));
    assign found    = found_chain[CAPACITY];

    assign add_ok    = s_fire && (cmd == CMD_ADD) && !is_full;
    assign take_ok   = s_fire && (cmd == CMD_TAKE) && !is_empty;
    assign cancel_ok = s_fire && (cmd == CMD_CANCEL) && found;

    assign ctl.take   = take_ok;
    assign ctl.cancel = cancel_ok;

    assign found_chain[0] = 1'b0;

    // Slot 0 is the head; each cell takes the entry of the cell behind it
    // when the row closes a gap. The last cell has no neighbour and keeps
    // its own entry, which then lies beyond the fill count.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [ID_W-1:0]  nb_id;
        logic [REF_W-1:0] nb_ref;

        if (i == CAPACITY - 1)
        begin : g_tail
            assign nb_id  = cell_id[i];
            assign nb_ref = cell_ref[i];
        end
        else
        begin : g_mid
            assign nb_id  = cell_id[i+1];
            assign nb_ref = cell_ref[i+1];
        end

        fqc_cell u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .occupied  (CNT_W'(i) < fill_reg),
            .load      (add_ok && (fill_reg == CNT_W'(i))),
            .key_id    (in_id),
            .key_ref   (in_ref),
            .nb_id     (nb_id),
            .nb_ref    (nb_ref),
            .found_in  (found_chain[i]),
            .found_out (found_chain[i+1]),
            .id        (cell_id[i]),
            .ref_out   (cell_ref[i])
        );
    end

    // Fill count and the result of the accepted item.
    always_comb
    begin
        fill_next = fill_reg;
        if (add_ok)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
        else if (take_ok || cancel_ok)
        begin
            fill_next = fill_reg - CNT_W'(1);
        end
    end

    // The reported occupancy is the fill count cut to five bits.
    assign fill_wide = 32'(fill_next);

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_taken_next  = out_taken_reg;
        out_id_next     = out_id_reg;
        out_ref_next    = out_ref_reg;
        out_occ_next    = out_occ_reg;

        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (s_fire)
        begin
            out_valid_next  = 1'b1;
            out_status_next = ST_OK;
            out_taken_next  = take_ok;
            out_id_next     = take_ok ? cell_id[0]  : '0;
            out_ref_next    = take_ok ? cell_ref[0] : '0;
            out_occ_next    = fill_wide[OCC_W-1:0];

            case (cmd)
                CMD_ADD:
                begin
                    if (is_full)
                    begin
                        out_status_next = ST_FULL;
                    end
                end
                CMD_TAKE:
                begin
                    if (is_empty)
                    begin
                        out_status_next = ST_EMPTY;
                    end
                end
                CMD_CANCEL:
                begin
                    if (is_empty)
                    begin
                        out_status_next = ST_EMPTY;
                    end
                    else if (!found)
                    begin
                        out_status_next = ST_NOT_FOUND;
                    end
                end
                default:
                begin
                    // The unused command code leaves the queue as it is.
                    out_status_next = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_taken_reg  <= out_taken_next;
        out_id_reg     <= out_id_next;
        out_ref_reg    <= out_ref_next;
        out_occ_reg    <= out_occ_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_occ_reg, out_ref_reg, out_id_reg};
    assign m_tuser  = {out_taken_reg, out_status_reg};

    // The fill count never passes the capacity.
    `ASSERT_ALWAYS(a_fill_bound, clk, rst_n, fill_reg <= CNT_W'(CAPACITY),
        "fill count above capacity")

    // A taken entry is only reported with an ok status.
    `ASSERT_IMPLIES(a_taken_ok, clk, rst_n, out_valid_reg && out_taken_reg,
        out_status_reg == ST_OK, "taken entry with a failing status")

    // Without a take the taken fields read as zero.
    `ASSERT_IMPLIES(a_taken_zero, clk, rst_n, out_valid_reg && !out_taken_reg,
        out_id_reg == '0 && out_ref_reg == '0, "taken fields set without a take")

    // A take from a non-empty queue removes exactly one entry.
    `ASSERT_NEXT(a_take_count, clk, rst_n, take_ok,
        fill_reg == $past(fill_reg) - CNT_W'(1), "take did not remove one entry")

endmodule

// ===== src/fqc_cell.sv =====
// ---------------------------------------------------------------------------
// fqc_cell
// One slot of the queue: holds an id and a record handle, compares its id
// with the search key and ripples the match on, and takes its neighbour's
// entry when the row closes a gap.
// ---------------------------------------------------------------------------
module fqc_cell (
    input  logic                       clk,
    input  fqc_pkg::cell_ctl_t         ctl,
    input  logic                       occupied,
    input  logic                       load,
    input  logic [fqc_pkg::ID_W-1:0]   key_id,
    input  logic [fqc_pkg::REF_W-1:0]  key_ref,
    input  logic [fqc_pkg::ID_W-1:0]   nb_id,
    input  logic [fqc_pkg::REF_W-1:0]  nb_ref,
    input  logic                       found_in,
    output logic                       found_out,
    output logic [fqc_pkg::ID_W-1:0]   id,
    output logic [fqc_pkg::REF_W-1:0]  ref_out
);
    import fqc_pkg::*;

    logic [ID_W-1:0]  id_reg,  id_next;
    logic [REF_W-1:0] ref_reg, ref_next;
    logic             shift;

    // A match only counts in a slot that holds an entry.
    assign found_out = found_in | (occupied & (id_reg == key_id));
    assign shift     = ctl.take | (ctl.cancel & found_out);

    always_comb
    begin
        id_next  = id_reg;
        ref_next = ref_reg;
        if (shift)
        begin
            id_next  = nb_id;
            ref_next = nb_ref;
        end
        else if (load)
        begin
            id_next  = key_id;
            ref_next = key_ref;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg  <= id_next;
        ref_reg <= ref_next;
    end

    assign id      = id_reg;
    assign ref_out = ref_reg;

endmodule

// ===== tb/fifo_queue_with_cancel_by_id_test.sv =====
// ---------------------------------------------------------------------------
// fifo_queue_with_cancel_by_id_test
// Self-checking bench for the tagged queue with cancel-by-id. A short table
// of directed items runs first. A long random run follows, biased towards
// filling, draining and hitting ids that are really held. Every result is
// compared field by field with a typed outcome or a behavioural model.
// ---------------------------------------------------------------------------
module fifo_queue_with_cancel_by_id_test;

    timeunit 1ns;
    timeprecision 1ps;

    import fqc_pkg::*;

    localparam int CAPACITY     = DEFAULT_CAPACITY;
    localparam int RANDOM_ITEMS = 1800;
    // The final stretch of the random run has no idling on either side.
    localparam int CALM_FROM    = 1600;
    // The item index at which the consumer is asked for one long stall.
    localparam int STALL_AT     = 700;
    localparam int STALL_CYCLES = 80;

    // One result as the block reports it.
    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic             taken_valid;
        logic [ID_W-1:0]  taken_id;
        logic [REF_W-1:0] taken_ref;
        logic [OCC_W-1:0] occupancy;
    } outcome_t;

    // One entry held in the queue model.
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [REF_W-1:0] handle;
    } slot_t;

    // A row of the directed table. The id and handle step up by one on
    // each repeat. Where known_out is set, the result is typed in the row;
    // otherwise the model supplies it.
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [ID_W-1:0]  id;
        logic [REF_W-1:0] handle;
        logic [7:0]       reps;
        logic             known_out;
        outcome_t         result;
    } plan_row_t;

    localparam plan_row_t DIRECTED [15] = '{
        // Take and cancel straight after reset find the queue empty.
        '{CMD_TAKE,   16'h0000, 16'h0000, 8'd1,  1'b1, '{ST_EMPTY, 1'b0, 16'h0, 16'h0, 5'd0}},
        '{CMD_CANCEL, 16'h0000, 16'h0000, 8'd1,  1'b1, '{ST_EMPTY, 1'b0, 16'h0, 16'h0, 5'd0}},
        // Extremes of id and handle.
        '{CMD_ADD,    16'h0000, 16'hFFFF, 8'd1,  1'b1, '{ST_OK, 1'b0, 16'h0, 16'h0, 5'd1}},
        '{CMD_ADD,    16'hFFFF, 16'h0000, 8'd1,  1'b1, '{ST_OK, 1'b0, 16'h0, 16'h0, 5'd2}},
        '{CMD_ADD,    16'h1234, 16'h5678, 8'd1,  1'b1, '{ST_OK, 1'b0, 16'h0, 16'h0, 5'd3}},
        // Cancel from the middle closes the gap; an unknown id is refused.
        '{CMD_CANCEL, 16'hFFFF, 16'h0000, 8'd1,  1'b1, '{ST_OK, 1'b0, 16'h0, 16'h0, 5'd2}},
        '{CMD_CANCEL, 16'hABCD, 16'h0000, 8'd1,  1'b1,
          '{ST_NOT_FOUND, 1'b0, 16'h0, 16'h0, 5'd2}},
        '{CMD_TAKE,   16'h0000, 16'h0000, 8'd1,  1'b1, '{ST_OK, 1'b1, 16'h0000, 16'hFFFF, 5'd1}},
        // Fill up to one short of capacity, then a duplicate id tops it up.
        '{CMD_ADD,    16'h0100, 16'hF000, 8'd14, 1'b0, '0},
        '{CMD_ADD,    16'h1234, 16'h0001, 8'd1,  1'b1, '{ST_OK, 1'b0, 16'h0, 16'h0, 5'd16}},
        // Add on a full queue is dropped; the unused code does nothing.
        '{CMD_ADD,    16'h5555, 16'hAAAA, 8'd1,  1'b1, '{ST_FULL, 1'b0, 16'h0, 16'h0, 5'd16}},
        '{CMD_NONE,   16'hFFFF, 16'hFFFF, 8'd1,  1'b1, '{ST_OK, 1'b0, 16'h0, 16'h0, 5'd16}},
        // Duplicate id: only the one nearest the head goes.
        '{CMD_CANCEL, 16'h1234, 16'h0000, 8'd1,  1'b0, '0},
        '{CMD_CANCEL, 16'h010D, 16'h0000, 8'd1,  1'b0, '0},
        '{CMD_TAKE,   16'h0000, 16'h0000, 8'd1,  1'b0, '0}
    };

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // entry_id[15:0], entry_ref[31:16]
    logic [1:0]  s_tuser;   // command[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // taken_id[15:0], taken_ref[31:16], occupancy[36:32],
                            // zero[39:37]
    logic [2:0]  m_tuser;   // status[1:0], taken_valid[2]

    // Queue model and the results still owed by the block, oldest first.
    slot_t    held [$];
    outcome_t owed [$];
    int       errors = 0;

    // Handshake between the producer and consumer processes.
    bit calm         = 1'b0;
    bit stall_req    = 1'b0;
    bit stall_active = 1'b0;

    fifo_queue_with_cancel_by_id #(
        .CAPACITY (CAPACITY)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial clk = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Applies one command to the queue model and returns what the block
    // should report for it. The occupancy is cut to its port width.
    function automatic outcome_t apply_command(input logic [CMD_W-1:0] cmd,
                                               input logic [ID_W-1:0]  id,
                                               input logic [REF_W-1:0] handle);
        outcome_t out;
        int       hit;
        out = '0;
        hit = -1;
        case (cmd)
            CMD_ADD:
                if (held.size() >= CAPACITY)
                    out.status = ST_FULL;
                else
                    held.push_back('{id, handle});
            CMD_TAKE:
                if (held.size() == 0)
                    out.status = ST_EMPTY;
                else
                begin
                    out.taken_valid = 1'b1;
                    out.taken_id    = held[0].id;
                    out.taken_ref   = held[0].handle;
                    void'(held.pop_front());
                end
            CMD_CANCEL:
                if (held.size() == 0)
                    out.status = ST_EMPTY;
                else
                begin
                    // The first match counted from the head is the one removed.
                    for (int i = 0; i < held.size(); i++)
                        if (hit < 0 && held[i].id == id)
                            hit = i;
                    if (hit < 0)
                        out.status = ST_NOT_FOUND;
                    else
                        held.delete(hit);
                end
            default:
                ;
        endcase
        out.occupancy = OCC_W'(held.size());
        return out;
    endfunction

    // Offers one item and waits until the block accepts it. The outcome is
    // worked out at the acceptance edge, so the model always sees the items
    // in the order the block took them.
    task automatic offer(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                         input logic [REF_W-1:0] handle, input logic known_out,
                         input outcome_t result);
        outcome_t modelled;
        s_tuser  <= cmd;
        s_tdata  <= {handle, id};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        modelled = apply_command(cmd, id, handle);
        owed.push_back(known_out ? result : modelled);
    endtask

    // Occasionally drops tvalid for a short burst between items, except in
    // quiet stretches, during the long consumer stall and near the end.
    task automatic producer_gap(input bit quiet);
        if (!quiet && !calm && !stall_active && $urandom_range(3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17))
                @(posedge clk);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // Consumer: random ready bursts, long all-ready stretches, one long
    // stall on request and a steady ready in the final stretch.
    initial
    begin
        bit on;
        int burst;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (stall_req)
            begin
                stall_req    = 1'b0;
                stall_active = 1'b1;
                m_tready <= 1'b0;
                for (int c = 0; c < STALL_CYCLES; c++)
                    @(posedge clk);
                stall_active = 1'b0;
            end
            else if (calm)
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                on    = ($urandom_range(2) != 0);
                burst = (on && $urandom_range(5) == 0) ? 48 : $urandom_range(1, 17);
                m_tready <= on;
                repeat (burst)
                    @(posedge clk);
            end
        end
    end

    // Result checker: every accepted result is matched against the oldest
    // outcome still owed.
    always @(posedge clk)
    begin
        outcome_t got;
        outcome_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{m_tuser[1:0], m_tuser[2], m_tdata[15:0], m_tdata[31:16],
                    m_tdata[36:32]};
            if (owed.size() == 0)
            begin
                $display("%0t ns: result with none expected, got %p", $time, got);
                errors++;
            end
            else
            begin
                want = owed.pop_front();
                check_field("status", 32'(want.status), 32'(got.status));
                check_field("taken_valid", 32'(want.taken_valid), 32'(got.taken_valid));
                check_field("taken_id", 32'(want.taken_id), 32'(got.taken_id));
                check_field("taken_ref", 32'(want.taken_ref), 32'(got.taken_ref));
                check_field("occupancy", 32'(want.occupancy), 32'(got.occupancy));
            end
        end
    end

    // Producer and end of run.
    initial
    begin
        int               add_weight;
        int               pick;
        int               waited;
        bit               quiet;
        logic [CMD_W-1:0] cmd;
        logic [ID_W-1:0]  id;
        logic [REF_W-1:0] handle;

        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= CMD_NONE;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table.
        for (int row = 0; row < $size(DIRECTED); row++)
            for (int k = 0; k < int'(DIRECTED[row].reps); k++)
            begin
                producer_gap(1'b0);
                offer(DIRECTED[row].cmd, DIRECTED[row].id + ID_W'(k),
                      DIRECTED[row].handle + REF_W'(k), DIRECTED[row].known_out,
                      DIRECTED[row].result);
            end

        // Random run. Each block of 100 items leans towards filling, holding
        // steady or draining, so full and empty are both visited often.
        // Ids come mostly from a small pool, and most cancels name an id that
        // is really held, so matches, duplicates and gaps at every position
        // are exercised.
        add_weight = 45;
        quiet      = 1'b0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 100 == 0)
            begin
                case ($urandom_range(2))
                    0:       add_weight = 70;
                    1:       add_weight = 45;
                    default: add_weight = 20;
                endcase
                quiet = ($urandom_range(3) == 0);
            end
            if (n == CALM_FROM)
                calm = 1'b1;
            if (n == STALL_AT)
                stall_req = 1'b1;

            pick   = $urandom_range(99);
            handle = REF_W'($urandom);
            if (pick < 3)
                cmd = CMD_NONE;
            else if (pick < 3 + add_weight)
                cmd = CMD_ADD;
            else if ($urandom_range(4) < 2)
                cmd = CMD_TAKE;
            else
                cmd = CMD_CANCEL;

            if (cmd == CMD_CANCEL && held.size() != 0 && $urandom_range(9) < 6)
                id = held[$urandom_range(held.size() - 1)].id;
            else if ($urandom_range(9) < 7)
                id = ID_W'($urandom_range(15));
            else
                id = ID_W'($urandom);

            producer_gap(quiet);
            offer(cmd, id, handle, 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        // Drain: wait for every owed result, within a bound, then keep running
        // so that any stray result would still be caught.
        waited = 0;
        while (owed.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (20)
            @(posedge clk);

        if (errors == 0 && owed.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
